// ===== hw/rtl/qpht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared types and constants of the quadratic probing hash table unit.
// ----------------------------------------------------------------------------
package qpht_pkg;

    // table geometry
    localparam int MAX_SLOTS = 1024;
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int SIZE_W    = IDX_W + 1;
    localparam int KEY_W     = 31;
    localparam int ENTRY_W   = KEY_W + 1;
    localparam int COLL_W    = 32;
    localparam int CNT_W     = 11;

    // remainder unit: key bits consumed per cycle
    localparam int MOD_BITS  = 4;
    localparam int KEY_PAD   = ((KEY_W + MOD_BITS - 1) / MOD_BITS) * MOD_BITS;
    localparam int MOD_STEPS = KEY_PAD / MOD_BITS;
    localparam int MCNT_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    // configuration reset values
    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST  = SIZE_W'(1021);
    localparam logic [SIZE_W-1:0] PROBE_LIMIT_RST = SIZE_W'(5);

    // operation codes
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_SEARCH = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    // register indexes (paddr[2])
    localparam logic REG_TABLE_SIZE  = 1'b0;
    localparam logic REG_PROBE_LIMIT = 1'b1;

    // sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_MOD   = 5'b00100,
        ST_ADDR  = 5'b01000,
        ST_CHECK = 5'b10000
    } t_state;

endpackage

// ===== hw/rtl/quadratic_probe_hash_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_unit
// Open-addressing hash table with quadratic probing over one slot memory.
// ----------------------------------------------------------------------------
//
//  channel   signals                                   beat taken when
//  -------   ---------------------------------------   -------------------------
//  command   start, busy, i_func, i_key, i_slot        start & !busy
//  result    o_done, o_index ... o_element_count       o_done (one cycle)
//  config    psel, penable, pwrite, paddr, pwdata      psel & penable & pwrite
//
//  Insert and search: accept the command, reduce the key mod table_size (4 bits
//  per cycle), then per probe a slot memory read and a check; the result
//  strobe comes on the cycle after the last check. Read slot: accept, slot
//  memory read, check. After reset a clearing pass writes all 1024 slots
//  empty, one per cycle; busy is high until it ends. Configuration writes are
//  taken at any time. The result is shown for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table_unit
    import qpht_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_func,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [IDX_W-1:0]     i_slot,
    // result
    output logic                 o_done,
    output logic [IDX_W-1:0]     o_index,
    output logic                 o_found,
    output logic [1:0]           o_status,
    output logic                 o_slot_valid,
    output logic [KEY_W-1:0]     o_slot_key,
    output logic [COLL_W-1:0]    o_collisions,
    output logic [CNT_W-1:0]     o_element_count,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // configuration registers
    logic [SIZE_W-1:0] r_table_size;
    logic [SIZE_W-1:0] r_probe_limit;

    // sequencer and operation registers
    t_state            r_state, n_state;
    logic [1:0]        r_func, n_func;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [SIZE_W-1:0] r_lim, n_lim;
    logic [SIZE_W-1:0] r_pcnt, n_pcnt;
    logic [IDX_W-1:0]  r_p, n_p;
    logic [IDX_W-1:0]  r_inc, n_inc;
    logic [IDX_W-1:0]  r_ccnt, n_ccnt;
    logic [SIZE_W-1:0] r_rem, n_rem;
    logic [KEY_PAD-1:0] r_ksh, n_ksh;
    logic [MCNT_W-1:0] r_mcnt, n_mcnt;

    // totals
    logic [COLL_W-1:0] r_coll, n_coll;
    logic [CNT_W-1:0]  r_elem, n_elem;

    // result registers
    logic              r_done, n_done;
    logic [IDX_W-1:0]  r_index, n_index;
    logic              r_found, n_found;
    logic [1:0]        r_status, n_status;
    logic              r_sval, n_sval;
    logic [KEY_W-1:0]  r_skey, n_skey;

    // slot memory: {valid, key}
    logic [ENTRY_W-1:0] r_slots [MAX_SLOTS];
    logic [ENTRY_W-1:0] r_rdata;
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [ENTRY_W-1:0] w_wdata;

    // combinational helpers
    logic [SIZE_W-1:0] w_eff_size;
    logic [SIZE_W-1:0] w_eff_lim;
    logic [SIZE_W-1:0] w_rem;
    logic [KEY_PAD-1:0] w_ksh;
    logic [SIZE_W:0]   w_t;
    logic [SIZE_W-1:0] w_psum;
    logic [IDX_W-1:0]  w_p_next;
    logic [SIZE_W-1:0] w_isum;
    logic [SIZE_W-1:0] w_isub;
    logic [IDX_W-1:0]  w_inc_next;
    logic [SIZE_W-1:0] w_pcnt_inc;
    logic              w_cfg_wr;

    // effective size and limit, zero raised to one, size clamped to MAX_SLOTS
    always_comb begin
        if (r_table_size == '0) begin
            w_eff_size = SIZE_W'(1);
        end else if (r_table_size > SIZE_W'(MAX_SLOTS)) begin
            w_eff_size = SIZE_W'(MAX_SLOTS);
        end else begin
            w_eff_size = r_table_size;
        end
        w_eff_lim = (r_probe_limit == '0) ? SIZE_W'(1) : r_probe_limit;
    end

    // remainder unit: MOD_BITS restoring steps per cycle
    always_comb begin
        w_rem = r_rem;
        w_ksh = r_ksh;
        w_t   = '0;
        for (int b = 0; b < MOD_BITS; b++) begin
            w_t   = {w_rem, w_ksh[KEY_PAD-1]};
            w_ksh = {w_ksh[KEY_PAD-2:0], 1'b0};
            if (w_t >= {1'b0, r_size}) begin
                w_t = w_t - {1'b0, r_size};
            end
            w_rem = w_t[SIZE_W-1:0];
        end
    end

    // next probe slot and increment (stepped by two), both kept below size
    always_comb begin
        w_psum = {1'b0, r_p} + {1'b0, r_inc};
        if (w_psum >= r_size) begin
            w_psum = w_psum - r_size;
        end
        w_p_next = w_psum[IDX_W-1:0];

        w_isum = {1'b0, r_inc} + SIZE_W'(2);
        if (w_isum >= r_size) begin
            w_isum = w_isum - r_size;
        end
        w_isub = w_isum;
        if (w_isub >= r_size) begin
            w_isub = w_isub - r_size;
        end
        w_inc_next = w_isub[IDX_W-1:0];

        w_pcnt_inc = r_pcnt + SIZE_W'(1);
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_func   = r_func;
        n_key    = r_key;
        n_size   = r_size;
        n_lim    = r_lim;
        n_pcnt   = r_pcnt;
        n_p      = r_p;
        n_inc    = r_inc;
        n_ccnt   = r_ccnt;
        n_rem    = r_rem;
        n_ksh    = r_ksh;
        n_mcnt   = r_mcnt;
        n_coll   = r_coll;
        n_elem   = r_elem;
        n_done   = 1'b0;
        n_index  = r_index;
        n_found  = r_found;
        n_status = r_status;
        n_sval   = r_sval;
        n_skey   = r_skey;
        w_we     = 1'b0;
        w_waddr  = r_p;
        w_wdata  = {1'b1, r_key};

        case (r_state)
            // clearing pass after reset
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_ccnt;
                w_wdata = '0;
                n_ccnt  = r_ccnt + IDX_W'(1);
                if (r_ccnt == IDX_W'(MAX_SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            // take a command beat
            ST_IDLE: begin
                if (start) begin
                    n_func = i_func;
                    n_key  = i_key;
                    n_size = w_eff_size;
                    n_lim  = (i_func == FUNC_INSERT) ? w_eff_size : w_eff_lim;
                    n_pcnt = '0;
                    case (i_func)
                        FUNC_INSERT, FUNC_SEARCH: begin
                            n_rem   = '0;
                            n_ksh   = KEY_PAD'(i_key);
                            n_mcnt  = '0;
                            n_inc   = (w_eff_size == SIZE_W'(1)) ? '0 : IDX_W'(1);
                            n_state = ST_MOD;
                        end
                        FUNC_READ: begin
                            n_p     = i_slot;
                            n_state = ST_ADDR;
                        end
                        default: begin
                            n_index  = '0;
                            n_found  = 1'b0;
                            n_status = STATUS_OK;
                            n_sval   = 1'b0;
                            n_skey   = '0;
                            n_done   = 1'b1;
                        end
                    endcase
                end
            end
            // key mod size
            ST_MOD: begin
                n_rem  = w_rem;
                n_ksh  = w_ksh;
                n_mcnt = r_mcnt + MCNT_W'(1);
                if (r_mcnt == MCNT_W'(MOD_STEPS - 1)) begin
                    n_p     = w_rem[IDX_W-1:0];
                    n_state = ST_ADDR;
                end
            end
            // slot memory read in flight
            ST_ADDR: begin
                n_state = ST_CHECK;
            end
            // inspect the slot
            ST_CHECK: begin
                n_found  = 1'b0;
                n_sval   = 1'b0;
                n_skey   = '0;
                n_index  = '0;
                n_status = STATUS_OK;
                case (r_func)
                    FUNC_READ: begin
                        n_index = r_p;
                        n_sval  = r_rdata[ENTRY_W-1];
                        n_skey  = r_rdata[KEY_W-1:0];
                        n_done  = 1'b1;
                        n_state = ST_IDLE;
                    end
                    FUNC_INSERT: begin
                        if (!r_rdata[ENTRY_W-1]) begin
                            w_we    = 1'b1;
                            n_index = r_p;
                            if (r_elem != {CNT_W{1'b1}}) begin
                                n_elem = r_elem + CNT_W'(1);
                            end
                            n_done  = 1'b1;
                            n_state = ST_IDLE;
                        end else begin
                            n_coll = r_coll + COLL_W'(1);
                            if (w_pcnt_inc == r_lim) begin
                                n_status = STATUS_FULL;
                                n_done   = 1'b1;
                                n_state  = ST_IDLE;
                            end else begin
                                n_pcnt  = w_pcnt_inc;
                                n_p     = w_p_next;
                                n_inc   = w_inc_next;
                                n_state = ST_ADDR;
                            end
                        end
                    end
                    FUNC_SEARCH: begin
                        if (!r_rdata[ENTRY_W-1]) begin
                            n_status = STATUS_NOT_FOUND;
                            n_done   = 1'b1;
                            n_state  = ST_IDLE;
                        end else if (r_rdata[KEY_W-1:0] == r_key) begin
                            n_found = 1'b1;
                            n_index = r_p;
                            n_done  = 1'b1;
                            n_state = ST_IDLE;
                        end else begin
                            n_coll = r_coll + COLL_W'(1);
                            if (w_pcnt_inc == r_lim) begin
                                n_status = STATUS_NOT_FOUND;
                                n_done   = 1'b1;
                                n_state  = ST_IDLE;
                            end else begin
                                n_pcnt  = w_pcnt_inc;
                                n_p     = w_p_next;
                                n_inc   = w_inc_next;
                                n_state = ST_ADDR;
                            end
                        end
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_state = ST_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = ST_CLEAR;
                n_ccnt  = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_ccnt  <= '0;
            r_coll  <= '0;
            r_elem  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ccnt  <= n_ccnt;
            r_coll  <= n_coll;
            r_elem  <= n_elem;
            r_done  <= n_done;
        end
    end

    // operation and result payload
    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_key    <= n_key;
        r_size   <= n_size;
        r_lim    <= n_lim;
        r_pcnt   <= n_pcnt;
        r_p      <= n_p;
        r_inc    <= n_inc;
        r_rem    <= n_rem;
        r_ksh    <= n_ksh;
        r_mcnt   <= n_mcnt;
        r_index  <= n_index;
        r_found  <= n_found;
        r_status <= n_status;
        r_sval   <= n_sval;
        r_skey   <= n_skey;
    end

    // slot memory, registered read at the current probe slot
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_slots[w_waddr] <= w_wdata;
        end
        r_rdata <= r_slots[r_p];
    end

    // configuration port
    assign w_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size  <= TABLE_SIZE_RST;
            r_probe_limit <= PROBE_LIMIT_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_TABLE_SIZE) begin
                r_table_size <= pwdata[SIZE_W-1:0];
            end else begin
                r_probe_limit <= pwdata[SIZE_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_PROBE_LIMIT) ? 32'(r_probe_limit) : 32'(r_table_size);
    assign pready = 1'b1;

    // outputs
    assign busy            = (r_state != ST_IDLE);
    assign o_done          = r_done;
    assign o_index         = r_index;
    assign o_found         = r_found;
    assign o_status        = r_status;
    assign o_slot_valid    = r_sval;
    assign o_slot_key      = r_skey;
    assign o_collisions    = r_coll;
    assign o_element_count = r_elem;

endmodule
